// ===== sv/rsaq_pkg.sv =====
// Package: command codes, payload structs and cell control for the alarm clock
package rsaq_pkg;

	localparam logic [15:0] RESET_PERIOD = 16'd12000;
	localparam int unsigned DATE_BITS = 32;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_SET    = 3'd1,
		CMD_ADD    = 3'd2,
		CMD_HALT   = 3'd3,
		CMD_RESUME = 3'd4
	} cmd_t;

	typedef enum logic {
		ST_OK   = 1'b0,
		ST_FULL = 1'b1
	} status_code_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] value;
		logic [7:0]  alarm_tag;
	} req_t;

	typedef struct packed {
		logic        fired;
		logic [7:0]  fired_tag;
		logic [31:0] current_time;
		logic        status;
	} rsp_t;

	typedef struct packed {
		logic                 insert;
		logic                 pop;
		logic [DATE_BITS-1:0] new_date;
	} cell_ctrl_t;

endpackage

// ===== sv/rsaq_cell.sv =====
// One alarm slot of the sorted chain: holds a date and tag, shifts with its neighbours
module rsaq_cell #(
	parameter int TAG_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rsaq_pkg::cell_ctrl_t                  ctrl,
	input  logic [TAG_BITS-1:0]                   new_tag,
	input  logic                                  prev_valid,
	input  logic                                  prev_le,
	input  logic [rsaq_pkg::DATE_BITS-1:0]        prev_date,
	input  logic [TAG_BITS-1:0]                   prev_tag,
	input  logic                                  next_valid,
	input  logic [rsaq_pkg::DATE_BITS-1:0]        next_date,
	input  logic [TAG_BITS-1:0]                   next_tag,
	output logic                                  valid,
	output logic [rsaq_pkg::DATE_BITS-1:0]        date,
	output logic [TAG_BITS-1:0]                   tag,
	output logic                                  le
);

	logic                           valid_q;
	logic [rsaq_pkg::DATE_BITS-1:0] date_q;
	logic [TAG_BITS-1:0]            tag_q;
	logic                           valid_d;
	logic [rsaq_pkg::DATE_BITS-1:0] date_d;
	logic [TAG_BITS-1:0]            tag_d;

	assign le    = valid_q && (date_q <= ctrl.new_date);
	assign valid = valid_q;
	assign date  = date_q;
	assign tag   = tag_q;

	always_comb begin
		valid_d = valid_q;
		date_d  = date_q;
		tag_d   = tag_q;
		priority if (ctrl.insert) begin
			if (!le) begin
				if (prev_le) begin
					valid_d = 1'b1;
					date_d  = ctrl.new_date;
					tag_d   = new_tag;
				end else begin
					valid_d = prev_valid;
					date_d  = prev_date;
					tag_d   = prev_tag;
				end
			end
		end else if (ctrl.pop) begin
			valid_d = next_valid;
			date_d  = next_date;
			tag_d   = next_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		date_q <= date_d;
		tag_q  <= tag_d;
	end

endmodule

// ===== sv/rtc_seconds_with_alarm_queue.sv =====
// Top level: seconds counter, command decode, alarm cell chain and APB register
//
// Requests enter on req (req_valid/req_ready) and carry a command: tick, set
// time, add alarm, halt or resume. Each request gives exactly one response on
// rsp (rsp_valid/rsp_ready) with the fired flag and tag, the seconds count
// after the request and the table-full status.
// A request is accepted while the response register is empty or being taken,
// and its response appears in the next cycle. One request is taken per
// cycle while rsp_ready is high: the alarm table is a chain of ALARM_SLOTS cells
// that each compare their own date against the new one and shift one place together.
// When rsp_ready is low the response holds and req_ready drops until it goes.
// tick_period lies at APB address 0; a second lasts tick_period + 1 ticks.
// Reset empties the table, clears both counters, starts counting and loads
// the period with 12000. No clearing pass is needed: slots have valid bits.
module rtc_seconds_with_alarm_queue #(
	parameter int ALARM_SLOTS = 8,
	parameter int TAG_BITS    = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rsaq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rsaq_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	localparam int DW = rsaq_pkg::DATE_BITS;

	logic [15:0]         period_q;
	logic [15:0]         sub_q;
	logic [DW-1:0]       sec_q;
	logic                running_q;
	logic                rsp_valid_q;
	rsaq_pkg::rsp_t      rsp_q;

	logic [ALARM_SLOTS-1:0] valid_c;
	logic [ALARM_SLOTS-1:0] le_c;
	logic [DW-1:0]          date_c [ALARM_SLOTS];
	logic [TAG_BITS-1:0]    tag_c  [ALARM_SLOTS];

	rsaq_pkg::cell_ctrl_t ctrl;
	rsaq_pkg::cmd_t       cmd;
	logic                 accept;
	logic [TAG_BITS-1:0]  tag_in;
	logic [DW-1:0]        sec_inc;
	logic                 wrap;
	logic                 due;
	logic                 full;
	logic [15:0]          sub_d;
	logic [DW-1:0]        sec_d;
	logic                 running_d;
	logic                 fired_d;
	logic [TAG_BITS-1:0]  ftag_d;
	logic                 status_d;
	logic                 cfg_wr;

	assign cmd     = rsaq_pkg::cmd_t'(req.command);
	assign accept  = req_valid && req_ready;
	assign tag_in  = TAG_BITS'(req.alarm_tag);
	assign sec_inc = sec_q + 1'b1;
	assign full    = valid_c[ALARM_SLOTS-1];
	assign due     = req.value <= sec_q;
	assign wrap    = running_q && (sub_q >= period_q);

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
	assign prdata = (paddr == 3'd0) ? {16'd0, period_q} : 32'd0;

	always_comb begin
		sub_d         = sub_q;
		sec_d         = sec_q;
		running_d     = running_q;
		fired_d       = 1'b0;
		ftag_d        = '0;
		status_d      = rsaq_pkg::ST_OK;
		ctrl.insert   = 1'b0;
		ctrl.pop      = 1'b0;
		ctrl.new_date = req.value;
		unique case (cmd)
			rsaq_pkg::CMD_TICK: begin
				if (running_q) begin
					if (wrap) begin
						sub_d = '0;
						sec_d = sec_inc;
						if (valid_c[0] && (date_c[0] == sec_inc)) begin
							ctrl.pop = 1'b1;
							fired_d  = 1'b1;
							ftag_d   = tag_c[0];
						end
					end else begin
						sub_d = sub_q + 1'b1;
					end
				end
			end
			rsaq_pkg::CMD_SET: begin
				sec_d = req.value;
			end
			rsaq_pkg::CMD_ADD: begin
				if (due) begin
					fired_d = 1'b1;
					ftag_d  = tag_in;
				end else if (full) begin
					status_d = rsaq_pkg::ST_FULL;
				end else begin
					ctrl.insert = 1'b1;
				end
			end
			rsaq_pkg::CMD_HALT: begin
				running_d = 1'b0;
				sub_d     = '0;
			end
			rsaq_pkg::CMD_RESUME: begin
				running_d = 1'b1;
				sub_d     = '0;
			end
			default: begin
			end
		endcase
		if (!accept) begin
			ctrl.insert = 1'b0;
			ctrl.pop    = 1'b0;
		end
	end

	for (genvar i = 0; i < ALARM_SLOTS; i++) begin : g_cell
		logic                prev_valid;
		logic                prev_le;
		logic [DW-1:0]       prev_date;
		logic [TAG_BITS-1:0] prev_tag;
		logic                next_valid;
		logic [DW-1:0]       next_date;
		logic [TAG_BITS-1:0] next_tag;

		if (i == 0) begin : g_first
			assign prev_valid = 1'b0;
			assign prev_le    = 1'b1;
			assign prev_date  = '0;
			assign prev_tag   = '0;
		end else begin : g_inner
			assign prev_valid = valid_c[i-1];
			assign prev_le    = le_c[i-1];
			assign prev_date  = date_c[i-1];
			assign prev_tag   = tag_c[i-1];
		end

		if (i == ALARM_SLOTS - 1) begin : g_last
			assign next_valid = 1'b0;
			assign next_date  = '0;
			assign next_tag   = '0;
		end else begin : g_mid
			assign next_valid = valid_c[i+1];
			assign next_date  = date_c[i+1];
			assign next_tag   = tag_c[i+1];
		end

		rsaq_cell #(
			.TAG_BITS(TAG_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_tag   (tag_in),
			.prev_valid(prev_valid),
			.prev_le   (prev_le),
			.prev_date (prev_date),
			.prev_tag  (prev_tag),
			.next_valid(next_valid),
			.next_date (next_date),
			.next_tag  (next_tag),
			.valid     (valid_c[i]),
			.date      (date_c[i]),
			.tag       (tag_c[i]),
			.le        (le_c[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= rsaq_pkg::RESET_PERIOD;
			sub_q       <= '0;
			sec_q       <= '0;
			running_q   <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				period_q <= pwdata[15:0];
			end
			if (accept) begin
				sub_q       <= sub_d;
				sec_q       <= sec_d;
				running_q   <= running_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.fired        <= fired_d;
			rsp_q.fired_tag    <= 8'(ftag_d);
			rsp_q.current_time <= sec_d;
			rsp_q.status       <= status_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.insert && ctrl.pop))
		else $error("insert and pop in the same cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		((valid_c + 1'b1) & valid_c) == '0)
		else $error("alarm slots not contiguous from the head");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.insert |=> valid_c[0])
		else $error("head slot empty after insert");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.fired && rsp.status))
		else $error("response both fired and full");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ctrl.pop) |=> (rsp.fired && rsp.current_time == $past(sec_inc)))
		else $error("pop without matching fired response");

endmodule
